### rtl/anp_pkg.sv
// ----------------------------------------------------------------------------
// ASCII number parser package
// Shared request/result types and character constants for the parser.
// ----------------------------------------------------------------------------
package anp_pkg;

    // Default longest string, counting the terminator position.
    localparam int MAX_POSITIONS_DEFAULT = 11;
    localparam int POS_W = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_K  = 8'h4B;
    localparam logic [7:0] CHAR_LC_K  = 8'h6B;
    localparam logic [7:0] CHAR_UC_M  = 8'h4D;
    localparam logic [7:0] CHAR_LC_M  = 8'h6D;
    localparam logic [7:0] CHAR_UC_X  = 8'h58;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;

    // Offsets that map a letter digit onto its value ('A' - 10, 'a' - 10).
    localparam logic [7:0] UC_HEX_BASE = 8'h37;
    localparam logic [7:0] LC_HEX_BASE = 8'h57;

    localparam int KILO_SHIFT = 10;
    localparam int MEGA_SHIFT = 20;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_flag;
    } req_t;

    typedef struct packed {
        logic [31:0] number_value;
        logic        accepted;
    } rsp_t;

endpackage

### rtl/ascii_number_parser.sv
// ----------------------------------------------------------------------------
// ASCII number parser
// Parses a character stream into a 32-bit decimal or hexadecimal value.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req) carries one character per
//   request; start_flag marks the first character of a new string. The result
//   channel (rsp_valid, rsp_stall, rsp) carries one result per string, given
//   when the string is accepted (NUL or k/m suffix) or rejected.
//   A request is registered in the request register at acceptance and is
//   evaluated from there once the result register can take its result;
//   the result is then registered in the result register.
//   One request per cycle is taken as long as the result side keeps up; the
//   parse state update (times-ten-and-add or hex shift) is the only loop.
//   When the receiver stalls, the result register holds its value and the
//   request register fills; req_stall then rises until the result is taken.
//   After reset the parser waits for a start flag and ignores characters
//   that come before it. Characters after a decision are ignored until the
//   next start flag.
// ----------------------------------------------------------------------------
module ascii_number_parser #(
    parameter int MAX_POSITIONS = anp_pkg::MAX_POSITIONS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  anp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output anp_pkg::rsp_t rsp
);

    localparam logic [anp_pkg::POS_W-1:0] LAST_POS = anp_pkg::POS_W'(MAX_POSITIONS - 1);
    localparam logic [anp_pkg::POS_W-1:0] POS_ONE  = anp_pkg::POS_W'(1);
    localparam logic [anp_pkg::POS_W-1:0] POS_TWO  = anp_pkg::POS_W'(2);

    logic                      in_vld_reg, in_vld_next;
    anp_pkg::req_t             in_reg;
    logic                      out_vld_reg, out_vld_next;
    anp_pkg::rsp_t             out_reg, out_next;

    logic [anp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [31:0]               acc_reg, acc_next;
    logic                      hex_reg, hex_next;
    logic                      zero_reg, zero_next;
    logic                      decided_reg, decided_next;

    logic                      advance;
    logic                      accept;

    // Effective state after a possible start flag.
    logic [anp_pkg::POS_W-1:0] pos_cur;
    logic [31:0]               acc_cur;
    logic                      hex_cur;
    logic                      zero_cur;
    logic                      decided_cur;

    logic [7:0]                c;
    logic                      is_dec;
    logic                      is_uc_hex;
    logic                      is_lc_hex;
    logic [3:0]                hex_val;
    logic [31:0]               dec_acc;
    logic                      done;
    logic                      ok;
    logic [31:0]               val;

    assign advance   = in_vld_reg && (!out_vld_reg || !rsp_stall);
    assign req_stall = in_vld_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    assign c         = in_reg.char_code;
    assign is_dec    = (c >= anp_pkg::CHAR_ZERO) && (c <= anp_pkg::CHAR_NINE);
    assign is_uc_hex = (c >= anp_pkg::CHAR_UC_A) && (c <= anp_pkg::CHAR_UC_F);
    assign is_lc_hex = (c >= anp_pkg::CHAR_LC_A) && (c <= anp_pkg::CHAR_LC_F);

    always_comb
    begin
        if (is_uc_hex)
            hex_val = 4'(c - anp_pkg::UC_HEX_BASE);
        else if (is_lc_hex)
            hex_val = 4'(c - anp_pkg::LC_HEX_BASE);
        else
            hex_val = 4'(c - anp_pkg::CHAR_ZERO);
    end

    always_comb
    begin
        if (in_reg.start_flag)
        begin
            pos_cur     = '0;
            acc_cur     = '0;
            hex_cur     = 1'b0;
            zero_cur    = 1'b0;
            decided_cur = 1'b0;
        end
        else
        begin
            pos_cur     = pos_reg;
            acc_cur     = acc_reg;
            hex_cur     = hex_reg;
            zero_cur    = zero_reg;
            decided_cur = decided_reg;
        end
    end

    // Multiply by ten as two shifts and an add, then add the digit.
    assign dec_acc = (acc_cur << 3) + (acc_cur << 1) + {28'd0, hex_val};

    always_comb
    begin
        pos_next     = pos_cur;
        acc_next     = acc_cur;
        hex_next     = hex_cur;
        zero_next    = zero_cur;
        decided_next = decided_cur;
        done         = 1'b0;
        ok           = 1'b0;
        val          = '0;

        if (!decided_cur)
        begin
            if (hex_cur)
            begin
                if (c == anp_pkg::CHAR_NUL)
                begin
                    done = 1'b1;
                    ok   = (pos_cur != POS_TWO);
                    val  = acc_cur;
                end
                else if ((pos_cur < LAST_POS) && (is_dec || is_uc_hex || is_lc_hex))
                begin
                    acc_next = {acc_cur[27:0], hex_val};
                    pos_next = pos_cur + POS_ONE;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            else
            begin
                if ((pos_cur == POS_ONE) && zero_cur &&
                    ((c == anp_pkg::CHAR_LC_X) || (c == anp_pkg::CHAR_UC_X)))
                begin
                    hex_next = 1'b1;
                    acc_next = '0;
                    pos_next = POS_TWO;
                end
                else if (c == anp_pkg::CHAR_NUL)
                begin
                    done = 1'b1;
                    ok   = 1'b1;
                    val  = acc_cur;
                end
                else if (((c == anp_pkg::CHAR_LC_K) || (c == anp_pkg::CHAR_UC_K)) &&
                         (pos_cur != '0))
                begin
                    done = 1'b1;
                    ok   = 1'b1;
                    val  = acc_cur << anp_pkg::KILO_SHIFT;
                end
                else if (((c == anp_pkg::CHAR_LC_M) || (c == anp_pkg::CHAR_UC_M)) &&
                         (pos_cur != '0))
                begin
                    done = 1'b1;
                    ok   = 1'b1;
                    val  = acc_cur << anp_pkg::MEGA_SHIFT;
                end
                else if ((pos_cur < LAST_POS) && is_dec)
                begin
                    acc_next = dec_acc;
                    if ((pos_cur == '0) && (c == anp_pkg::CHAR_ZERO))
                        zero_next = 1'b1;
                    pos_next = pos_cur + POS_ONE;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            if (done)
                decided_next = 1'b1;
        end
    end

    always_comb
    begin
        out_next.number_value = ok ? val : 32'd0;
        out_next.accepted     = ok;
    end

    always_comb
    begin
        if (accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        if (advance)
            out_vld_next = done;
        else if (out_vld_reg && !rsp_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pos_reg     <= '0;
            acc_reg     <= '0;
            hex_reg     <= 1'b0;
            zero_reg    <= 1'b0;
            decided_reg <= 1'b1;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                pos_reg     <= pos_next;
                acc_reg     <= acc_next;
                hex_reg     <= hex_next;
                zero_reg    <= zero_next;
                decided_reg <= decided_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= req;
        if (advance && done)
            out_reg <= out_next;
    end

endmodule
